[sv/servo_packet_router_assert.svh]
// assertion macros for the servo packet router
`ifndef SERVO_PACKET_ROUTER_ASSERT_SVH
`define SERVO_PACKET_ROUTER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked while out of reset
`define SPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define SPR_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SPR_ASSERT(lbl, prop, msg)
`define SPR_ASSERT_ANY(lbl, prop, msg)
`endif

`endif

[sv/spr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package spr_pkg;

    // default parameter values
    localparam int MAX_DEVICES_DEF        = 16;
    localparam int RETURN_BUFFER_SIZE_DEF = 64;
    localparam int MAX_RETURN_PACKET_DEF  = 64;
    localparam int BUFFER_DEPTH_DEF       = 32;

    // register reset values and indexes
    localparam logic [7:0]  OWN_ID_RST  = 8'd200;
    localparam logic [15:0] TIMEOUT_RST = 16'd5000;
    localparam logic REG_OWN_ID  = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    // result kinds
    localparam logic [2:0] KIND_BUS   = 3'd0;
    localparam logic [2:0] KIND_PING  = 3'd1;
    localparam logic [2:0] KIND_RANGE = 3'd2;
    localparam logic [2:0] KIND_READ  = 3'd3;
    localparam logic [2:0] KIND_WRITE = 3'd4;
    localparam logic [2:0] KIND_SYNC  = 3'd5;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_value;
        logic [7:0] address;
        logic [7:0] count;
        logic       last;
    } t_out;

    typedef struct packed {
        logic accept;
        logic exec;
        logic emit;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;
        logic stream;
        logic last_elem;
    } t_ctl_stat;

endpackage
`default_nettype wire

[sv/spr_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "servo_packet_router_assert.svh"
module spr_datapath #(
    parameter int MAX_DEVICES        = spr_pkg::MAX_DEVICES_DEF,
    parameter int RETURN_BUFFER_SIZE = spr_pkg::RETURN_BUFFER_SIZE_DEF,
    parameter int MAX_RETURN_PACKET  = spr_pkg::MAX_RETURN_PACKET_DEF,
    parameter int BUFFER_DEPTH       = spr_pkg::BUFFER_DEPTH_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire spr_pkg::t_in i_in_data,
    input  wire  [7:0]       i_own_id,
    input  wire  [15:0]      i_timeout,
    input  wire spr_pkg::t_ctl_cmd i_cmd,
    output spr_pkg::t_ctl_stat o_stat,
    output spr_pkg::t_out    o_out_data,
    output logic             o_out_valid,
    input  wire              i_out_ready
);
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [7:0] SYNC_BYTE    = 8'hFF;
    localparam logic [7:0] BROADCAST_ID = 8'hFE;
    localparam logic [7:0] INS_PING     = 8'h01;
    localparam logic [7:0] INS_READ     = 8'h02;
    localparam logic [7:0] INS_WRITE    = 8'h03;
    localparam logic [7:0] INS_SYNC     = 8'h84;

    typedef enum logic [3:0] {
        PH_FIRST, PH_SECOND, PH_ID, PH_LEN, PH_LEN_FOREIGN,
        PH_INSTR, PH_PING, PH_PARAMS, PH_PASS
    } t_phase;

    // latched item and parser state
    logic          r_op;
    logic [7:0]    r_ch;
    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_bc, n_bc;
    logic [7:0]    r_sum, n_sum;
    logic [15:0]   r_idle, n_idle;
    logic [7:0]    r_pass, n_pass;
    logic [7:0]    r_id, n_id, r_len, n_len, r_ins, n_ins, r_p5, n_p5, r_p6, n_p6;

    // packet buffer
    logic [7:0]    r_mem [BUFFER_DEPTH];
    logic [7:0]    r_rdata;

    // stream sequencer and output register
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_left;
    logic [2:0]    r_s_kind;
    logic [7:0]    r_s_addr, r_s_cnt;
    spr_pkg::t_out r_out;
    logic          r_out_valid;

    // plan for the current item
    logic          wr_en, p_single, do_flush, p_stream;
    logic [2:0]    p_kind;
    logic [7:0]    p_byte, p_addr, p_cnt;
    logic [CW-1:0] p_n, bc_inc;
    logic [AW-1:0] p_start;
    logic [2:0]    s_kind;
    logic [7:0]    s_addr, s_cnt, p5v, p6v, sum_inc;
    logic [15:0]   idle_sat, prod;
    logic          sync_bad;

    assign bc_inc  = r_bc + CW'(1);
    assign p5v     = (r_bc == CW'(5)) ? r_ch : r_p5;
    assign p6v     = (r_bc == CW'(6)) ? r_ch : r_p6;
    assign sum_inc = r_sum + r_ch;
    assign prod    = 16'(p6v) * (16'(r_len) - 16'd4);
    assign idle_sat = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;
    assign sync_bad = (r_len < 8'd4) || (p6v == 8'd0)
        || ({1'b0, p6v} > 9'(RETURN_BUFFER_SIZE - 6))
        || (prod > 16'(MAX_RETURN_PACKET - 6));

    // parse decision
    always_comb begin
        n_phase = r_phase; n_bc = r_bc; n_sum = r_sum; n_idle = r_idle;
        n_pass = r_pass; n_id = r_id; n_len = r_len; n_ins = r_ins;
        n_p5 = r_p5; n_p6 = r_p6;
        wr_en = 1'b0; p_single = 1'b0; do_flush = 1'b0;
        p_kind = spr_pkg::KIND_BUS; p_byte = 8'd0; p_addr = 8'd0; p_cnt = 8'd0;
        p_n = '0; p_start = '0;
        s_kind = spr_pkg::KIND_BUS; s_addr = 8'd0; s_cnt = 8'd0;
        if (!r_op) begin
            n_idle = 16'd0;
            case (r_phase)
                PH_FIRST: begin
                    if (r_ch == SYNC_BYTE) begin
                        wr_en = 1'b1; n_bc = CW'(1); n_phase = PH_SECOND;
                    end else begin
                        p_single = 1'b1; p_byte = r_ch;
                    end
                end
                PH_SECOND: begin
                    wr_en = 1'b1; n_bc = bc_inc;
                    if (r_ch == SYNC_BYTE) n_phase = PH_ID;
                    else do_flush = 1'b1;
                end
                PH_ID: begin
                    if (r_ch == SYNC_BYTE) begin
                        p_single = 1'b1; p_byte = SYNC_BYTE;
                    end else begin
                        wr_en = 1'b1; n_bc = bc_inc; n_id = r_ch;
                        if (r_ch != i_own_id && r_ch != BROADCAST_ID) begin
                            p_n = bc_inc; n_phase = PH_LEN_FOREIGN;
                        end else begin
                            n_phase = PH_LEN;
                        end
                    end
                end
                PH_LEN_FOREIGN: begin
                    wr_en = 1'b1; n_bc = bc_inc;
                    p_single = 1'b1; p_byte = r_ch;
                    n_pass = (r_ch == 8'd0) ? 8'd1 : r_ch;
                    n_phase = PH_PASS;
                end
                PH_LEN: begin
                    wr_en = 1'b1; n_bc = bc_inc; n_len = r_ch;
                    if ({1'b0, r_ch} > 9'd1 && {1'b0, r_ch} < 9'(MAX_DEVICES + 4)
                            && {1'b0, r_ch} + 9'd4 <= 9'(BUFFER_DEPTH)) begin
                        n_phase = PH_INSTR;
                    end else begin
                        p_single = 1'b1; p_kind = spr_pkg::KIND_RANGE;
                        do_flush = 1'b1;
                    end
                end
                PH_INSTR: begin
                    wr_en = 1'b1; n_bc = bc_inc; n_ins = r_ch;
                    n_sum = r_id + r_ch + r_len;
                    if (r_ch == INS_SYNC) n_phase = PH_PARAMS;
                    else if (r_id == i_own_id && r_ch == INS_PING) n_phase = PH_PING;
                    else if (r_id == i_own_id && (r_ch == INS_READ || r_ch == INS_WRITE))
                        n_phase = PH_PARAMS;
                    else do_flush = 1'b1;
                end
                PH_PING: begin
                    wr_en = 1'b1; n_bc = bc_inc;
                    if (i_own_id + 8'd3 + r_ch == 8'hFF) begin
                        p_single = 1'b1; p_kind = spr_pkg::KIND_PING;
                        n_phase = PH_FIRST; n_bc = '0;
                    end else begin
                        do_flush = 1'b1;
                    end
                end
                PH_PARAMS: begin
                    wr_en = 1'b1; n_bc = bc_inc; n_sum = sum_inc;
                    n_p5 = p5v; n_p6 = p6v;
                    if (9'(bc_inc) >= {1'b0, r_len} + 9'd4) begin
                        if (sum_inc != 8'hFF) begin
                            do_flush = 1'b1;
                        end else begin
                            n_phase = PH_FIRST; n_bc = '0;
                            if (r_ins == INS_SYNC) begin
                                if (sync_bad) begin
                                    p_single = 1'b1; p_kind = spr_pkg::KIND_RANGE;
                                end else begin
                                    p_n = CW'(r_len - 8'd2); p_start = AW'(5);
                                    s_kind = spr_pkg::KIND_SYNC; s_addr = r_id;
                                    s_cnt = r_len - 8'd2;
                                end
                            end else if (r_ins == INS_READ) begin
                                p_single = 1'b1; p_kind = spr_pkg::KIND_READ;
                                p_addr = p5v;
                                p_cnt = (r_len >= 8'd3) ? p6v : 8'd0;
                            end else if (r_len > 8'd3) begin
                                p_n = CW'(r_len - 8'd3); p_start = AW'(6);
                                s_kind = spr_pkg::KIND_WRITE; s_addr = p5v;
                                s_cnt = r_len - 8'd3;
                            end
                        end
                    end
                end
                PH_PASS: begin
                    p_single = 1'b1; p_byte = r_ch;
                    n_pass = (r_pass > 8'd0) ? r_pass - 8'd1 : r_pass;
                    if (n_pass == 8'd0) begin
                        n_phase = PH_FIRST; n_bc = '0;
                    end
                end
                default: begin
                    n_phase = PH_FIRST; n_bc = '0;
                end
            endcase
            // flush buffered bytes, keeping a trailing sync byte
            if (do_flush) begin
                if (r_ch == SYNC_BYTE) begin
                    p_n = r_bc; n_bc = CW'(1); n_phase = PH_SECOND;
                end else begin
                    p_n = bc_inc; n_bc = '0; n_phase = PH_FIRST;
                end
            end
        end else if (r_phase != PH_FIRST) begin
            // idle tick and timeout
            n_idle = idle_sat;
            if (idle_sat > i_timeout) begin
                if (r_phase != PH_LEN_FOREIGN && r_phase != PH_PASS) p_n = r_bc;
                n_phase = PH_FIRST; n_bc = '0; n_pass = 8'd0; n_idle = 16'd0;
            end
        end
    end

    assign p_stream = (p_n != '0);

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_bc    <= '0;
            r_sum   <= 8'd0;
            r_idle  <= 16'd0;
            r_pass  <= 8'd0;
        end else if (i_cmd.exec) begin
            r_phase <= n_phase;
            r_bc    <= n_bc;
            r_sum   <= n_sum;
            r_idle  <= n_idle;
            r_pass  <= n_pass;
        end
    end

    // latched item and captured header fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op <= i_in_data.operation;
            r_ch <= i_in_data.data_byte;
        end
        if (i_cmd.exec) begin
            r_id <= n_id; r_len <= n_len; r_ins <= n_ins;
            r_p5 <= n_p5; r_p6 <= n_p6;
        end
    end

    // buffer write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en && r_bc < CW'(BUFFER_DEPTH)) r_mem[r_bc[AW-1:0]] <= r_ch;
        r_rdata <= r_mem[r_idx];
    end

    // stream sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_cmd.exec) begin
            r_left <= p_n;
        end else if (i_cmd.emit) begin
            r_left <= r_left - CW'(1);
        end
        if (i_cmd.exec) begin
            r_idx    <= p_start;
            r_s_kind <= s_kind;
            r_s_addr <= s_addr;
            r_s_cnt  <= s_cnt;
        end else if (i_cmd.emit) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.exec && p_single) || i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.exec && p_single) begin
            r_out <= '{kind: p_kind, byte_value: p_byte, address: p_addr,
                       count: p_cnt, last: !p_stream};
        end else if (i_cmd.emit) begin
            r_out <= '{kind: r_s_kind, byte_value: r_rdata, address: r_s_addr,
                       count: r_s_cnt, last: (r_left == CW'(1))};
        end
    end

    assign o_out_data       = r_out;
    assign o_out_valid      = r_out_valid;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.stream    = p_stream;
    assign o_stat.last_elem = (r_left == CW'(1));

    `SPR_ASSERT(a_first_empty, (r_phase == PH_FIRST) |-> (r_bc == '0), "search with filled buffer")
    `SPR_ASSERT(a_bc_range, r_bc <= CW'(BUFFER_DEPTH), "byte count past buffer depth")
    `SPR_ASSERT(a_pass_left, (r_phase == PH_PASS) |-> (r_pass != 8'd0), "pass with no bytes left")
    `SPR_ASSERT(a_emit_left, i_cmd.emit |-> (r_left != '0), "stream emit with nothing left")
endmodule
`default_nettype wire

[sv/spr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module spr_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire spr_pkg::t_ctl_stat i_stat,
    output spr_pkg::t_ctl_cmd  o_cmd
);
    typedef enum logic [1:0] { S_IDLE, S_EXEC, S_ADDR, S_EMIT } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;

    // commands to the datapath
    assign o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec   = (r_state == S_EXEC) && i_stat.out_free;
    assign o_cmd.emit   = (r_state == S_EMIT) && i_stat.out_free;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: begin
                if (i_stat.out_free) n_state = i_stat.stream ? S_ADDR : S_IDLE;
            end
            S_ADDR: n_state = S_EMIT;
            S_EMIT: begin
                if (i_stat.out_free) n_state = i_stat.last_elem ? S_IDLE : S_ADDR;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;
endmodule
`default_nettype wire

[sv/servo_packet_router.sv]
`timescale 1ns / 1ps
`default_nettype none
// servo packet router: parses protocol 1 instruction packets from a host byte stream
// input channel (i_in_valid / o_in_ready): one item is a host byte or one idle tick
// output channel (o_out_valid / i_out_ready): bus bytes, status, read and write items;
//   last marks the final item produced by one input
// apb port: register 0 own_id at 0x0, register 1 timeout_ticks at 0x4
// an input is taken in the idle state and decided in the exec state, which waits
//   for a free output register; a single result is registered by that decision
// streamed results (flush, write or sync-read bytes) come from the packet buffer
//   through its registered read port, an address state then an emit state per byte
// one item is handled at a time; ready returns once its last result is registered
// a stalled receiver holds the output register and the sequencer waits on it
// reset clears the parser to sync search, empties the output and restores registers
// the buffer needs no clearing: only entries written for the current packet are read
module servo_packet_router #(
    parameter int MAX_DEVICES        = spr_pkg::MAX_DEVICES_DEF,
    parameter int RETURN_BUFFER_SIZE = spr_pkg::RETURN_BUFFER_SIZE_DEF,
    parameter int MAX_RETURN_PACKET  = spr_pkg::MAX_RETURN_PACKET_DEF,
    parameter int BUFFER_DEPTH       = spr_pkg::BUFFER_DEPTH_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  wire spr_pkg::t_in i_in_data,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output spr_pkg::t_out  o_out_data,
    input  wire            psel,
    input  wire            penable,
    input  wire            pwrite,
    input  wire  [2:0]     paddr,
    input  wire  [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    logic [7:0]          r_own_id;
    logic [15:0]         r_timeout;
    spr_pkg::t_ctl_cmd   cmd;
    spr_pkg::t_ctl_stat  stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id  <= spr_pkg::OWN_ID_RST;
            r_timeout <= spr_pkg::TIMEOUT_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                spr_pkg::REG_OWN_ID:  r_own_id  <= pwdata[7:0];
                spr_pkg::REG_TIMEOUT: r_timeout <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[2])
            spr_pkg::REG_OWN_ID:  prdata = {24'd0, r_own_id};
            spr_pkg::REG_TIMEOUT: prdata = {16'd0, r_timeout};
            default:              prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    spr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    spr_datapath #(
        .MAX_DEVICES        (MAX_DEVICES),
        .RETURN_BUFFER_SIZE (RETURN_BUFFER_SIZE),
        .MAX_RETURN_PACKET  (MAX_RETURN_PACKET),
        .BUFFER_DEPTH       (BUFFER_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_own_id    (r_own_id),
        .i_timeout   (r_timeout),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );
endmodule
`default_nettype wire
